// ===== design/sfps_pkg.sv =====
// Shared types and codes for the shift FIFO with popped-value sum.
// Holds the request, response and configuration beat layouts and the cell control.
// Depends on nothing; the cell, top level and checker refer to it by scoped names.
package sfps_pkg;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_PUSH       = 2'd0,
        OP_POP        = 2'd1,
        OP_READ_HEAD  = 2'd2,
        OP_READ_INDEX = 2'd3
    } t_op;

    // Response error codes.
    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_PUSH_FULL   = 3'd1,
        ERR_HEAD_EMPTY  = 3'd2,
        ERR_POP_EMPTY   = 3'd3,
        ERR_READ_EMPTY  = 3'd4,
        ERR_INDEX_RANGE = 3'd5
    } t_err;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned CAP_W   = 5;
    localparam int unsigned OCC_W   = 5;
    localparam int unsigned SUM_W   = 64;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // One request beat.
    typedef struct packed {
        t_op                       opcode;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } t_req;

    // One response beat.
    typedef struct packed {
        logic signed [VALUE_W-1:0] read_data;
        t_err                      error_code;
        logic                      is_empty;
        logic                      is_full;
        logic [OCC_W-1:0]          occupancy;
        logic signed [SUM_W-1:0]   popped_total;
    } t_rsp;

    // One configuration beat: the capacity register.
    typedef struct packed {
        logic [CAP_W-1:0] capacity;
    } t_cfg;

    // Per-cell control from the queue controller.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== design/sfps_chan_if.sv =====
// Valid/ready channel used for the request, response and configuration ports.
// The payload type is a parameter; the layouts come from sfps_pkg.
// Depends on nothing else.
interface sfps_chan_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== design/sfps_cell.sv =====
// One storage cell of the shift FIFO.
// It loads a pushed value, takes its upper neighbor's value on a pop, or holds.
// Uses sfps_pkg for the cell control struct.
module sfps_cell #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  sfps_pkg::t_cell_ctl   i_ctl,
    input  logic [DATA_WIDTH-1:0] i_push_data,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // A pop and a push never come in the same beat.
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_next_data;
        end else if (i_ctl.load) begin
            n_data = i_push_data;
        end
    end

    // Payload only, so no reset.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== design/shift_fifo_with_popped_sum.sv =====
// Shift FIFO with a running sum of popped values: controller and row of cells.
// Depends on sfps_pkg, sfps_chan_if and sfps_cell.
//
//   channel  | dir | beat       | fields
//   ---------+-----+------------+--------------------------------------------
//   i_req    | in  | request    | opcode, value, index
//   o_rsp    | out | response   | read_data, error_code, is_empty, is_full,
//            |     |            | occupancy, popped_total
//   i_cfg    | in  | config     | capacity (always ready)
//
// When a request is accepted, all cells shift or the cell at the tail loads at the
// same edge, and its response sits in the output register on the next cycle.
// A new request is taken whenever the output register is empty or being drained,
// so one request per cycle flows through while o_rsp.ready stays high.
// A stalled response holds i_req.ready low. Reset clears count, sum, capacity
// (to 16) and the output valid; cell contents are left as they are.
module shift_fifo_with_popped_sum #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfps_chan_if.sink   i_req,
    sfps_chan_if.source o_rsp,
    sfps_chan_if.sink   i_cfg
);

    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > sfps_pkg::CAP_W) ? CW : sfps_pkg::CAP_W;
    localparam int unsigned RDN  = (DEPTH < 16) ? DEPTH : 16;
    localparam int unsigned SW   = sfps_pkg::SUM_W;

    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic signed [SW-1:0]            r_sum;
    logic signed [SW-1:0]            n_sum;
    logic [sfps_pkg::CAP_W-1:0]      r_capacity;
    logic                            r_rsp_valid;
    logic                            n_rsp_valid;
    sfps_pkg::t_rsp                  r_rsp;
    sfps_pkg::t_rsp                  n_rsp;

    sfps_pkg::t_req                  w_req;
    logic                            w_accept;
    logic                            w_push_ok;
    logic                            w_pop_ok;
    logic [CMPW-1:0]                 w_cap_raw;
    logic [CMPW-1:0]                 w_cap;
    logic [CMPW-1:0]                 w_count_ext;
    logic [CMPW-1:0]                 w_next_ext;
    logic [CMPW-1:0]                 w_index_ext;
    logic [DATA_WIDTH-1:0]           w_push_data;
    logic [DATA_WIDTH-1:0]           w_index_word;
    logic signed [SW-1:0]            w_head_sx;
    logic signed [SW-1:0]            w_index_sx;
    sfps_pkg::t_err                  w_err;
    logic signed [sfps_pkg::VALUE_W-1:0] w_rd;

    logic [DATA_WIDTH-1:0]           w_cell_data [DEPTH];
    sfps_pkg::t_cell_ctl             w_cell_ctl  [DEPTH];

    assign w_req    = i_req.data;
    assign w_accept = i_req.valid && i_req.ready;

    // Handshakes: take a request when the output register is free this cycle.
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    // Effective capacity: the register clamped to 1..DEPTH.
    assign w_cap_raw = CMPW'(r_capacity);
    always_comb begin
        w_cap = w_cap_raw;
        if (w_cap_raw == '0) begin
            w_cap = CMPW'(1);
        end else if (w_cap_raw > CMPW'(DEPTH)) begin
            w_cap = CMPW'(DEPTH);
        end
    end

    assign w_count_ext = CMPW'(r_count);
    assign w_index_ext = CMPW'(w_req.index);

    // Pushed value: sign-extend the 32-bit input, keep the stored width.
    assign w_push_data = DATA_WIDTH'(SW'(w_req.value));

    // Indexed read select over the cells that an index can reach.
    always_comb begin
        w_index_word = w_cell_data[0];
        for (int i = 0; i < RDN; i++) begin
            if (w_req.index == sfps_pkg::INDEX_W'(i)) begin
                w_index_word = w_cell_data[i];
            end
        end
    end

    assign w_head_sx  = SW'($signed(w_cell_data[0]));
    assign w_index_sx = SW'($signed(w_index_word));

    // Request decode: error code, read data and the push and pop enables.
    always_comb begin
        w_err     = sfps_pkg::ERR_OK;
        w_rd      = '0;
        w_push_ok = 1'b0;
        w_pop_ok  = 1'b0;
        case (w_req.opcode)
            sfps_pkg::OP_PUSH: begin
                if (w_count_ext >= w_cap) begin
                    w_err = sfps_pkg::ERR_PUSH_FULL;
                end else begin
                    w_push_ok = 1'b1;
                end
            end
            sfps_pkg::OP_POP: begin
                if (r_count == '0) begin
                    w_err = sfps_pkg::ERR_POP_EMPTY;
                end else begin
                    w_pop_ok = 1'b1;
                end
            end
            sfps_pkg::OP_READ_HEAD: begin
                if (r_count == '0) begin
                    w_err = sfps_pkg::ERR_HEAD_EMPTY;
                end else begin
                    w_rd = w_head_sx[sfps_pkg::VALUE_W-1:0];
                end
            end
            sfps_pkg::OP_READ_INDEX: begin
                if (r_count == '0) begin
                    w_err = sfps_pkg::ERR_READ_EMPTY;
                end else if (w_index_ext >= w_count_ext
                             || w_index_ext >= CMPW'(DEPTH)) begin
                    w_err = sfps_pkg::ERR_INDEX_RANGE;
                end else begin
                    w_rd = w_index_sx[sfps_pkg::VALUE_W-1:0];
                end
            end
            default: begin
                w_err = sfps_pkg::ERR_OK;
            end
        endcase
    end

    // Next count and popped sum, committed only on an accepted beat.
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (w_accept && w_push_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_accept && w_pop_ok) begin
            n_count = r_count - CW'(1);
            n_sum   = r_sum + w_head_sx;
        end
    end

    assign w_next_ext = CMPW'(n_count);

    // Response register contents.
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (w_accept) begin
            n_rsp_valid        = 1'b1;
            n_rsp.read_data    = w_rd;
            n_rsp.error_code   = w_err;
            n_rsp.is_empty     = (n_count == '0);
            n_rsp.is_full      = (w_next_ext >= w_cap);
            n_rsp.occupancy    = w_next_ext[sfps_pkg::OCC_W-1:0];
            n_rsp.popped_total = n_sum;
        end else if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_capacity  <= sfps_pkg::CAP_RESET;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.data.capacity;
            end
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    // Row of cells; entry 0 is the head and a pop moves every entry down.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_cell_ctl[g].shift = w_accept && w_pop_ok;
        assign w_cell_ctl[g].load  = w_accept && w_push_ok && (r_count == CW'(g));

        if (g == DEPTH - 1) begin : g_last
            sfps_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_cell_ctl[g]),
                .i_push_data(w_push_data),
                .i_next_data(w_cell_data[g]),
                .o_data     (w_cell_data[g])
            );
        end else begin : g_mid
            sfps_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_cell_ctl[g]),
                .i_push_data(w_push_data),
                .i_next_data(w_cell_data[g+1]),
                .o_data     (w_cell_data[g])
            );
        end
    end

endmodule

// ===== design/sfps_chk.sv =====
// Port-level checker for the shift FIFO, bound to the top level.
// Depends on sfps_pkg for the response layout and error codes.
module sfps_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input sfps_pkg::t_rsp i_rsp_data
);

    // An accepted request shows its response on the next cycle.
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> i_rsp_valid)
        else $error("accepted request gave no response");

    // A failed request reads back zero.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.error_code != sfps_pkg::ERR_OK
        |-> i_rsp_data.read_data == '0)
        else $error("failed request carries read data");

    // Empty flag agrees with occupancy, and the queue is never full and empty.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.is_empty == (i_rsp_data.occupancy == '0))
                        && !(i_rsp_data.is_full && i_rsp_data.is_empty))
        else $error("inconsistent empty/full flags");

    // A stalled response beat holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled response changed");

endmodule

bind shift_fifo_with_popped_sum sfps_chk u_sfps_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_req_valid(i_req.valid),
    .i_req_ready(i_req.ready),
    .i_rsp_valid(o_rsp.valid),
    .i_rsp_ready(o_rsp.ready),
    .i_rsp_data (o_rsp.data)
);
